[design/hsmo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsmo_pkg
// Shared widths, word layout and types of the sphere mask override block.
// ----------------------------------------------------------------------------
package hsmo_pkg;

  localparam int MAX_SPHERES_DEF = 64;

  localparam int SIDX_W    = 6;
  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int VALUE_W   = 32;
  localparam int ACTIVE_W  = 7;

  // input word layout, lowest bit first
  localparam int SIDX_LSB  = 0;
  localparam int X_LSB     = SIDX_LSB + SIDX_W;
  localparam int Y_LSB     = X_LSB + COORD_W;
  localparam int Z_LSB     = Y_LSB + COORD_W;
  localparam int RAD_LSB   = Z_LSB + COORD_W;
  localparam int GAMMA_LSB = RAD_LSB + RADIUS_W;
  localparam int SUB_LSB   = GAMMA_LSB + VALUE_W;
  localparam int IN_USED_W = SUB_LSB + VALUE_W;
  localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_DATA_W = VALUE_W;

  localparam logic signed [VALUE_W+1:0] ONE_Q16 = 34'sd65536;
  localparam logic signed [VALUE_W+1:0] SAT_MIN = -34'sd2147483648;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic        [RADIUS_W-1:0] radius;
    logic signed [COORD_W-1:0]  z;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  x;
  } sphere_t;

endpackage
`default_nettype wire

[design/hard_sphere_mask_override.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hard_sphere_mask_override
// Tests a grid point against a table of spheres and overrides the closure
// value with -gamma-1 when the point lies strictly inside an active sphere.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                      tuser
// in_      in   sphere_index, x, y, z, radius, gamma, sub  mode
// out_     out  closure_value                              inside_res
// cfg_     in   active_spheres (write only)                -
//
// a load word writes the sphere table directly when sphere_index < MAX_SPHERES
// a query reads n table entries, n = min(active_spheres, MAX_SPHERES), one
// table read per cycle, through the absolute difference, square and compare stages;
// a hit stops the walk
// a finished result waits in the output register while the next word is taken
// a second result holds in_tready low until the first is taken
// reset is synchronous; the sphere table is not cleared
// ----------------------------------------------------------------------------
module hard_sphere_mask_override
  import hsmo_pkg::*;
#(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // sphere_index, coord_x, coord_y, coord_z, radius, gamma_value, sub_value
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // closure_value
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // inside_res
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [ACTIVE_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_SPHERES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [ACTIVE_W-1:0]       active_r;
  logic [CW-1:0]             limit_r, limit_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic                      hit_r, hit_nxt;
  logic                      v1_r, v2_r, v3_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]        out_value_r;
  logic                      out_inside_r;

  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic signed [VALUE_W-1:0] gamma_r, sub_r;
  logic [COORD_W-1:0]        mx_r, my_r, mz_r;
  logic [RADIUS_W-1:0]       rad_r;
  logic [2*COORD_W-1:0]      sqx_r, sqy_r, sqz_r;
  logic [2*RADIUS_W-1:0]     r2_r;

  logic                      in_acc, is_query, load_we, issue, drained, slot_free;
  logic                      load_out, in_sphere;
  logic [SIDX_W-1:0]         in_sidx;
  logic [CW-1:0]             cfg_lim;
  sphere_t                   wr_entry, rd_entry;
  logic [2*COORD_W+1:0]      dist_sum;
  logic signed [VALUE_W+1:0] neg_val;
  logic [VALUE_W-1:0]        res_value;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign is_query  = (in_tuser == MODE_QUERY);
  assign in_sidx   = in_tdata[SIDX_LSB +: SIDX_W];
  assign load_we   = in_acc & (in_tuser == MODE_LOAD) & (32'(in_sidx) < MAX_SPHERES);

  assign wr_entry.x      = in_tdata[X_LSB +: COORD_W];
  assign wr_entry.y      = in_tdata[Y_LSB +: COORD_W];
  assign wr_entry.z      = in_tdata[Z_LSB +: COORD_W];
  assign wr_entry.radius = in_tdata[RAD_LSB +: RADIUS_W];

  assign cfg_lim = (32'(active_r) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(active_r);
  assign issue   = (state_r == ST_RUN) && (k_r < limit_r) && !hit_r;
  assign drained = (state_r == ST_RUN) && !issue && !v1_r && !v2_r && !v3_r;

  hsmo_ram #(
    .WIDTH ($bits(sphere_t)),
    .DEPTH (MAX_SPHERES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_sidx)),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (k_r[AW-1:0]),
    .rdata (rd_entry)
  );

  // distance test of the entry in the last stage
  assign dist_sum = (2*COORD_W+2)'(sqx_r) + (2*COORD_W+2)'(sqy_r)
                  + (2*COORD_W+2)'(sqz_r);
  assign in_sphere = (sqx_r < (2*COORD_W)'(r2_r)) && (sqy_r < (2*COORD_W)'(r2_r))
                  && (sqz_r < (2*COORD_W)'(r2_r)) && (dist_sum < (2*COORD_W+2)'(r2_r));

  // override value, saturated on the low side
  assign neg_val   = -(VALUE_W+2)'(gamma_r) - ONE_Q16;
  assign res_value = hit_r ? ((neg_val < SAT_MIN) ? VALUE_W'(SAT_MIN) : neg_val[VALUE_W-1:0])
                           : sub_r;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (v3_r && in_sphere) begin
      hit_nxt = 1'b1;
    end
    if (issue) begin
      k_nxt = k_r + CW'(1);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = ST_RUN;
          limit_nxt = cfg_lim;
          k_nxt     = '0;
          hit_nxt   = 1'b0;
        end
      end
      ST_RUN: begin
        if (drained) begin
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      limit_r     <= '0;
      k_r         <= '0;
      hit_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      k_r         <= k_nxt;
      hit_r       <= hit_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (load_out) begin
        out_value_r  <= res_value;
        out_inside_r <= hit_r;
      end
    end
  end

  // query capture and distance pipeline
  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      px_r    <= in_tdata[X_LSB +: COORD_W];
      py_r    <= in_tdata[Y_LSB +: COORD_W];
      pz_r    <= in_tdata[Z_LSB +: COORD_W];
      gamma_r <= in_tdata[GAMMA_LSB +: VALUE_W];
      sub_r   <= in_tdata[SUB_LSB +: VALUE_W];
    end
    mx_r  <= abs_diff(px_r, rd_entry.x);
    my_r  <= abs_diff(py_r, rd_entry.y);
    mz_r  <= abs_diff(pz_r, rd_entry.z);
    rad_r <= rd_entry.radius;
    sqx_r <= (2*COORD_W)'(mx_r) * (2*COORD_W)'(mx_r);
    sqy_r <= (2*COORD_W)'(my_r) * (2*COORD_W)'(my_r);
    sqz_r <= (2*COORD_W)'(mz_r) * (2*COORD_W)'(mz_r);
    r2_r  <= (2*RADIUS_W)'(rad_r) * (2*RADIUS_W)'(rad_r);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_inside_r;

endmodule
`default_nettype wire

[design/hsmo_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsmo_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsmo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_hard_sphere_mask_override.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hard_sphere_mask_override
// Loads the sphere table and sends grid point queries through the in_ stream.
// A local copy of the table and the active count predicts, for each query
// taken, the closure value and the inside flag. The out_ stream is checked in
// order against those predictions. Directed words cover zero and full radius,
// the sphere boundary, coordinate extremes and override saturation; random
// words then run under several active counts, including one, the full table
// and a count above it, with random stalls on both streams but for the last two.
// ----------------------------------------------------------------------------
module tb_hard_sphere_mask_override;
  import hsmo_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic                      mode;
    logic [SIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       rad;
    logic signed [VALUE_W-1:0] gam;
    logic signed [VALUE_W-1:0] sub;
    bit                        hold;
  } word_t;

  typedef struct {
    logic signed [VALUE_W-1:0] closure;
    logic                      in_sphere;
  } closure_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [ACTIVE_W-1:0] cfg_wdata = '0;

  // predictor copy of the block state
  logic signed [COORD_W-1:0] tbl_cx [TABLE_DEPTH];
  logic signed [COORD_W-1:0] tbl_cy [TABLE_DEPTH];
  logic signed [COORD_W-1:0] tbl_cz [TABLE_DEPTH];
  logic [RADIUS_W-1:0]       tbl_rad [TABLE_DEPTH];
  logic [ACTIVE_W-1:0]       mask_active = '0;

  // table as seen by the stimulus generator
  logic signed [COORD_W-1:0] gen_cx [TABLE_DEPTH];
  logic signed [COORD_W-1:0] gen_cy [TABLE_DEPTH];
  logic signed [COORD_W-1:0] gen_cz [TABLE_DEPTH];
  logic [RADIUS_W-1:0]       gen_rad [TABLE_DEPTH];
  int gen_active = 0;

  word_t    word_fifo [$];
  closure_t closure_due [$];
  word_t    live_word;
  bit       word_live = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  always #10 clk = ~clk;

  hard_sphere_mask_override i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic logic [63:0] sq_gap(logic signed [COORD_W-1:0] a,
                                         logic signed [COORD_W-1:0] b);
    longint d;
    logic [63:0] m;
    d = longint'(a) - longint'(b);
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  // updates the table for a load, returns 1 with the closure for a query
  function automatic bit apply_word(word_t w, output closure_t res);
    int n;
    bit hit;
    logic [63:0] r2, dx, dy, dz;
    longint ov;
    res.closure = '0;
    res.in_sphere = 1'b0;
    if (w.mode == MODE_LOAD) begin
      tbl_cx[w.idx] = w.x;
      tbl_cy[w.idx] = w.y;
      tbl_cz[w.idx] = w.z;
      tbl_rad[w.idx] = w.rad;
      return 0;
    end
    n = (int'(mask_active) > TABLE_DEPTH) ? TABLE_DEPTH : int'(mask_active);
    hit = 0;
    for (int k = 0; k < n && !hit; k++) begin
      r2 = 64'(tbl_rad[k]) * 64'(tbl_rad[k]);
      dx = sq_gap(w.x, tbl_cx[k]);
      dy = sq_gap(w.y, tbl_cy[k]);
      dz = sq_gap(w.z, tbl_cz[k]);
      if (dx < r2 && dy < r2 && dz < r2 && dx + dy + dz < r2) hit = 1;
    end
    if (hit) begin
      ov = -longint'(w.gam) - 64'sd65536;
      if (ov < -64'sd2147483648) ov = -64'sd2147483648;
      if (ov > 64'sd2147483647) ov = 64'sd2147483647;
      res.closure = VALUE_W'(ov);
      res.in_sphere = 1'b1;
    end else begin
      res.closure = w.sub;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // word acceptance, result checking and run limit
  always @(posedge clk) begin
    closure_t pred;
    closure_t due;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (apply_word(live_word, pred)) closure_due.push_back(pred);
        word_live = 0;
      end
      if (out_tvalid && out_tready) begin
        if (closure_due.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, '0);
        end else begin
          due = closure_due.pop_front();
          if (out_tdata !== due.closure)
            report_mismatch("closure_value", out_tdata, due.closure);
          if (out_tuser !== due.in_sphere)
            report_mismatch("inside_res", 32'(out_tuser), 32'(due.in_sphere));
        end
      end
    end
  end

  // stream driver
  always @(negedge clk) begin
    logic [IN_DATA_W-1:0] packed_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!word_live) begin
        if (word_fifo.size() != 0 && !(word_fifo[0].hold && closure_due.size() != 0)
            && $urandom_range(0, 99) >= send_idle_pct) begin
          live_word = word_fifo.pop_front();
          word_live = 1;
          packed_word = '0;
          packed_word[SIDX_LSB +: SIDX_W] = live_word.idx;
          packed_word[X_LSB +: COORD_W] = live_word.x;
          packed_word[Y_LSB +: COORD_W] = live_word.y;
          packed_word[Z_LSB +: COORD_W] = live_word.z;
          packed_word[RAD_LSB +: RADIUS_W] = live_word.rad;
          packed_word[GAMMA_LSB +: VALUE_W] = live_word.gam;
          packed_word[SUB_LSB +: VALUE_W] = live_word.sub;
          in_tdata <= packed_word;
          in_tuser <= live_word.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic push_load(int idx, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [30:0] rad);
    word_t w;
    w = '{MODE_LOAD, SIDX_W'(idx), x, y, z, rad, 32'($urandom), 32'($urandom), 0};
    gen_cx[idx] = x;
    gen_cy[idx] = y;
    gen_cz[idx] = z;
    gen_rad[idx] = rad;
    word_fifo.push_back(w);
  endtask

  task automatic push_query(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] gam,
                            logic signed [31:0] sub, bit hold);
    word_t w;
    w = '{MODE_QUERY, SIDX_W'($urandom), x, y, z, 31'($urandom), gam, sub, hold};
    word_fifo.push_back(w);
  endtask

  // waits until nothing is queued or outstanding, then lets the block settle
  task automatic drain_words();
    while (word_fifo.size() != 0 || word_live || closure_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_active(int n);
    drain_words();
    cfg_wdata <= ACTIVE_W'(n);
    cfg_we <= 1'b1;
    mask_active = ACTIVE_W'(n);
    gen_active = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] near_coord(logic signed [31:0] c,
                                                    logic [30:0] r);
    longint off;
    off = longint'($urandom_range(0, {r, 1'b0})) - longint'(r);
    return 32'(longint'(c) + off);
  endfunction

  function automatic logic [30:0] rand_radius();
    int w;
    logic [31:0] m;
    w = $urandom_range(0, 31);
    m = (32'h1 << w) - 32'h1;
    return 31'($urandom & m);
  endfunction

  function automatic logic signed [31:0] rand_centre();
    if ($urandom_range(0, 1) == 0) return 32'($urandom);
    return 32'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
  endfunction

  function automatic logic signed [31:0] rand_gamma();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'shffff0000;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic push_random_words(int count);
    int pick, k, ax;
    logic signed [31:0] px, py, pz;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      k = (gen_active > 0) ? $urandom_range(0, gen_active - 1) : 0;
      if (pick < 30) begin
        push_load($urandom_range(0, TABLE_DEPTH - 1), rand_centre(), rand_centre(),
                  rand_centre(), rand_radius());
      end else begin
        if (pick < 85 && gen_active > 0) begin
          px = gen_cx[k];
          py = gen_cy[k];
          pz = gen_cz[k];
          if (pick < 70) begin
            px = near_coord(px, gen_rad[k]);
            py = near_coord(py, gen_rad[k]);
            pz = near_coord(pz, gen_rad[k]);
          end else if (pick >= 78) begin
            // one axis exactly on the surface
            ax = $urandom_range(0, 2);
            if (ax == 0) px = 32'(longint'(px) + longint'(gen_rad[k]));
            else if (ax == 1) py = 32'(longint'(py) - longint'(gen_rad[k]));
            else pz = 32'(longint'(pz) + longint'(gen_rad[k]));
          end
        end else begin
          px = 32'($urandom);
          py = 32'($urandom);
          pz = 32'($urandom);
        end
        push_query(px, py, pz, rand_gamma(), 32'($urandom), i == count / 2);
      end
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no active spheres: everything passes through
    set_active(0);
    push_query(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 0);
    push_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff, 0);
    push_load(0, 32'sh0, 32'sh0, 32'sh0, 31'h0);
    push_load(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
    push_load(2, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h10000);
    push_load(3, 32'sh00050000, -32'sh00030000, 32'sh00007fff, 31'h20000);
    push_load(63, 32'sh0, 32'sh0, 32'sh0, 31'h7fffffff);

    // directed checks on four spheres
    set_active(4);
    push_query(32'sh0, 32'sh0, 32'sh0, 32'sh12345678, 32'sh0badf00d, 0);
    push_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh0, 0);
    push_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh0, 0);
    push_query(32'sh80010000, 32'sh80000000, 32'sh80000000, 32'sh0,
               32'sh7fffffff, 0);
    push_query(32'sh8000ffff, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0, 0);
    push_query(32'sh00060000, -32'sh00020000, 32'sh00017fff, -32'sh00010000,
               32'sh0, 0);
    push_query(32'sh00068000, -32'sh00018000, 32'sh00007fff, 32'sh0,
               32'sh55aa55aa, 0);
    push_query(32'sh00050000, -32'sh00030000, 32'sh00007fff, 32'shffff0000,
               32'sh0, 0);
    push_query(32'sh00070000, -32'sh00030000, 32'sh00007fff, 32'sh1,
               32'sh0, 0);

    // fill the whole table before any larger count
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_load(i, rand_centre(), rand_centre(), rand_centre(), rand_radius());
    set_active(TABLE_DEPTH);
    push_random_words(130);

    send_idle_pct = 64;
    recv_idle_pct = 22;
    set_active(127);
    push_random_words(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_active(1);
    push_random_words(60);
    set_active($urandom_range(2, TABLE_DEPTH - 1));
    push_random_words(60);

    drain_words();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
